// ===== src/m3sat_pkg.sv =====
// Shared constants, token types and helpers for the max-3-SAT hill climber.
`timescale 1ns / 1ps
package m3sat_pkg;

    localparam int DEF_MAX_VARS    = 256;
    localparam int DEF_MAX_CLAUSES = 1024;

    // Field widths (fixed by the item format)
    localparam int KIND_W  = 2;
    localparam int SLOT_W  = 10;
    localparam int LIT_W   = 10;
    localparam int SCORE_W = 11;
    localparam int NV_W    = 9;
    localparam int NC_W    = 11;
    localparam int CFG_W   = 11;
    localparam int NLIT    = 3;

    // Internal widths sized for the largest supported configuration
    localparam int IDX_W  = 12;
    localparam int CNT_W  = 17;
    localparam int GAIN_W = 18;

    localparam logic [CNT_W-1:0] SCORE_SAT = CNT_W'(2047);

    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SET   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLIMB = 2'd2;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd3;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_VARS    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_CLAUSES = 1'b1;

    typedef struct packed {
        logic [LIT_W-1:0] third;
        logic [LIT_W-1:0] second;
        logic [LIT_W-1:0] first;
    } t_clause;

    typedef struct packed {
        logic             ok;
        logic             neg;
        logic [IDX_W-1:0] idx;
    } t_lit;

    // Lane A: clause collects literal truth on its way down the row
    typedef struct packed {
        logic                  valid;
        logic                  sweep;
        t_lit [NLIT-1:0]       lit;
        logic [NLIT-1:0]       truth;
    } t_tok_a;

    typedef struct packed {
        logic             up;
        logic             dn;
        logic [IDX_W-1:0] idx;
    } t_delta;

    // Lane B: per-variable score deltas, or the sweep that picks the best flip
    typedef struct packed {
        logic                     valid;
        logic                     sweep;
        t_delta [NLIT-1:0]        d;
        logic signed [GAIN_W-1:0] best_gain;
        logic [IDX_W-1:0]         best_idx;
        logic                     found;
    } t_tok_b;

    typedef struct packed {
        logic             wr;
        logic             flip;
        logic [IDX_W-1:0] idx;
        logic             val;
    } t_var_op;

    function automatic logic [SCORE_W-1:0] sat_score(input logic [CNT_W-1:0] s);
        sat_score = (s > SCORE_SAT) ? SCORE_W'(SCORE_SAT) : s[SCORE_W-1:0];
    endfunction

endpackage

// ===== src/m3sat_in_if.sv =====
// Input item channel.
`timescale 1ns / 1ps
interface m3sat_in_if;
    import m3sat_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic [SLOT_W-1:0]        slot;
    logic signed [LIT_W-1:0]  lit_first;
    logic signed [LIT_W-1:0]  lit_second;
    logic signed [LIT_W-1:0]  lit_third;
    logic                     bit_value;

    modport source (output valid, kind, slot, lit_first, lit_second, lit_third, bit_value,
                    input ready);
    modport sink (input valid, kind, slot, lit_first, lit_second, lit_third, bit_value,
                  output ready);
endinterface

// ===== src/m3sat_out_if.sv =====
// Result item channel.
`timescale 1ns / 1ps
interface m3sat_out_if;
    import m3sat_pkg::*;
    logic               valid;
    logic               ready;
    logic [SCORE_W-1:0] local_score;
    logic [SCORE_W-1:0] best_score;
    logic               all_satisfied;
    logic               var_value;

    modport source (output valid, local_score, best_score, all_satisfied, var_value,
                    input ready);
    modport sink (input valid, local_score, best_score, all_satisfied, var_value,
                  output ready);
endinterface

// ===== src/max_3sat_hill_climb.sv =====
// Top level of the max-3-SAT steepest-ascent hill climber.
`timescale 1ns / 1ps
// Every input item gives one result transfer. Clause loads, variable sets and
// variable reads may follow back to back as long as the result port does not
// stall. A climb runs in passes: each pass streams the clause table out of the
// clause RAM, one clause per cycle, through a row of MAX_VARS cells (one per
// variable) on two token lanes. Lane A collects the truth of each literal from
// the cells that own them; between the lanes the clause is scored and turned
// into +1/-1 flip deltas; lane B adds those deltas into each cell's gain
// counter. A sweep token follows the last clause and picks the first cell with
// the strictly largest positive gain. A climb takes (flips + 1) passes. The
// climbed assignment stays in the cells and can be read back with read items.
// No clearing pass is needed after reset.
module max_3sat_hill_climb #(
    parameter int MAX_VARS    = m3sat_pkg::DEF_MAX_VARS,
    parameter int MAX_CLAUSES = m3sat_pkg::DEF_MAX_CLAUSES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [m3sat_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [m3sat_pkg::CFG_W-1:0]    i_cfg_data,
    m3sat_in_if.sink                       i_in,
    m3sat_out_if.source                    o_out
);
    import m3sat_pkg::*;

    localparam int AW = (MAX_CLAUSES > 1) ? $clog2(MAX_CLAUSES) : 1;
    localparam int VW = $clog2(MAX_VARS);
    localparam logic [IDX_W:0]     MV = (IDX_W + 1)'(MAX_VARS);
    localparam logic [CNT_W-1:0]   MC = CNT_W'(MAX_CLAUSES);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;

    // config
    logic [NV_W-1:0]  r_num_vars;
    logic [NC_W-1:0]  r_num_clauses;
    logic [IDX_W:0]   w_nv_eff;
    logic [CNT_W-1:0] w_nc_eff;

    // control
    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_addr, n_addr;
    logic [CNT_W-1:0] r_base, n_base;
    logic [CNT_W-1:0] r_best, n_best;
    logic             r_rd_v, r_rd_sweep;
    logic             w_rd_clause, w_issue;
    logic             w_xfer;

    // output register
    logic               r_out_valid, n_out_valid;
    logic [SCORE_W-1:0] r_local, n_local;
    logic [SCORE_W-1:0] r_best_o, n_best_o;
    logic               r_all, n_all;
    logic               r_vv, n_vv;

    // datapath
    t_clause          w_ram_q;
    t_tok_a           r_a0, n_a0;
    t_tok_b           r_b0, n_b0;
    t_tok_a           w_a [MAX_VARS+1];
    t_tok_b           w_b [MAX_VARS+1];
    logic [MAX_VARS-1:0] w_vars;
    t_var_op          w_op;
    t_tok_a           w_tail;
    t_tok_b           w_done;
    logic             w_sat;
    logic             w_read_bit;
    logic             w_ram_we;

    assign w_nv_eff = ((IDX_W + 1)'(r_num_vars) < MV) ? (IDX_W + 1)'(r_num_vars) : MV;
    assign w_nc_eff = (CNT_W'(r_num_clauses) < MC) ? CNT_W'(r_num_clauses) : MC;

    assign i_in.ready = (r_state == ST_IDLE) && (!r_out_valid || o_out.ready);
    assign w_xfer     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_vars    <= NV_W'(1);
            r_num_clauses <= NC_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_NUM_VARS:    r_num_vars    <= i_cfg_data[NV_W-1:0];
                REG_NUM_CLAUSES: r_num_clauses <= i_cfg_data[NC_W-1:0];
                default: ;
            endcase
        end
    end

    // clause RAM: written by load items, read once per cycle by a pass
    assign w_ram_we = w_xfer && i_in.kind == KIND_LOAD && CNT_W'(i_in.slot) < MC;

    m3sat_ram #(
        .W     ($bits(t_clause)),
        .DEPTH (MAX_CLAUSES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (AW'(i_in.slot)),
        .i_wdata ({i_in.lit_third, i_in.lit_second, i_in.lit_first}),
        .i_re    (w_issue),
        .i_raddr (AW'(r_addr)),
        .o_rdata (w_ram_q)
    );

    function automatic t_lit decode_lit(input logic [LIT_W-1:0] lit,
                                        input logic [IDX_W:0] nv);
        t_lit             l;
        logic [LIT_W-1:0] mag;
        mag   = lit[LIT_W-1] ? (~lit + LIT_W'(1)) : lit;
        l.neg = lit[LIT_W-1];
        l.ok  = (mag != '0) && ((IDX_W + 1)'(mag) <= nv);
        l.idx = IDX_W'(mag - LIT_W'(1));
        return l;
    endfunction

    // issue sequencer: one clause read per cycle, then the sweep marker
    assign w_rd_clause = r_addr < w_nc_eff;
    assign w_issue     = (r_state == ST_ISSUE);

    always_comb begin
        n_a0       = '0;
        n_a0.valid = r_rd_v;
        n_a0.sweep = r_rd_sweep;
        if (!r_rd_sweep) begin
            n_a0.lit[0] = decode_lit(w_ram_q.first, w_nv_eff);
            n_a0.lit[1] = decode_lit(w_ram_q.second, w_nv_eff);
            n_a0.lit[2] = decode_lit(w_ram_q.third, w_nv_eff);
        end
    end

    // the cell row
    assign w_a[0] = r_a0;
    assign w_b[0] = r_b0;

    for (genvar g = 0; g < MAX_VARS; g++) begin : g_cell
        m3sat_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (w_op),
            .i_a     (w_a[g]),
            .i_b     (w_b[g]),
            .o_a     (w_a[g+1]),
            .o_b     (w_b[g+1]),
            .o_var   (w_vars[g])
        );
    end

    // between lanes: score the clause and derive a delta per distinct variable
    assign w_tail = w_a[MAX_VARS];
    assign w_sat  = |w_tail.truth;

    always_comb begin
        logic same, after, dup;
        n_b0       = '0;
        n_b0.valid = w_tail.valid;
        n_b0.sweep = w_tail.sweep;
        for (int k = 0; k < NLIT; k++) begin
            after = 1'b0;
            dup   = 1'b0;
            for (int j = 0; j < NLIT; j++) begin
                same  = w_tail.lit[j].ok && w_tail.lit[k].ok &&
                        w_tail.lit[j].idx == w_tail.lit[k].idx;
                after = after | (w_tail.truth[j] ^ same);
                if (j < k && same) begin
                    dup = 1'b1;
                end
            end
            n_b0.d[k].idx = w_tail.lit[k].idx;
            n_b0.d[k].up  = !w_tail.sweep && w_tail.lit[k].ok && !dup && after && !w_sat;
            n_b0.d[k].dn  = !w_tail.sweep && w_tail.lit[k].ok && !dup && !after && w_sat;
        end
    end

    assign w_done = w_b[MAX_VARS];

    always_comb begin
        w_op      = '0;
        w_op.wr   = w_xfer && i_in.kind == KIND_SET && (IDX_W + 1)'(i_in.slot) < MV;
        w_op.idx  = IDX_W'(i_in.slot);
        w_op.val  = i_in.bit_value;
        if (r_state == ST_WAIT && w_done.valid && w_done.sweep && w_done.found) begin
            w_op.flip = 1'b1;
            w_op.idx  = w_done.best_idx;
        end
    end

    assign w_read_bit = ((IDX_W + 1)'(i_in.slot) < MV) ? w_vars[VW'(i_in.slot)] : 1'b0;

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_base      = r_base;
        n_best      = r_best;
        n_out_valid = r_out_valid && !o_out.ready;
        n_local     = r_local;
        n_best_o    = r_best_o;
        n_all       = r_all;
        n_vv        = r_vv;

        if (w_tail.valid && !w_tail.sweep && w_sat) begin
            n_base = r_base + CNT_W'(1);
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_xfer) begin
                    if (i_in.kind == KIND_CLIMB) begin
                        n_state = ST_ISSUE;
                        n_addr  = '0;
                        n_base  = '0;
                    end else begin
                        n_out_valid = 1'b1;
                        n_local     = '0;
                        n_best_o    = sat_score(r_best);
                        n_all       = (r_best == w_nc_eff);
                        n_vv        = (i_in.kind == KIND_READ) ? w_read_bit : 1'b0;
                    end
                end
            end
            ST_ISSUE: begin
                if (w_rd_clause) begin
                    n_addr = r_addr + CNT_W'(1);
                end else begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (w_done.valid && w_done.sweep) begin
                    if (w_done.found) begin
                        n_state = ST_ISSUE;
                        n_addr  = '0;
                        n_base  = '0;
                    end else begin
                        n_state     = ST_IDLE;
                        n_best      = (r_base > r_best) ? r_base : r_best;
                        n_out_valid = 1'b1;
                        n_local     = sat_score(r_base);
                        n_best_o    = sat_score(n_best);
                        n_all       = (n_best == w_nc_eff);
                        n_vv        = 1'b0;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_addr      <= '0;
            r_base      <= '0;
            r_best      <= '0;
            r_rd_v      <= 1'b0;
            r_rd_sweep  <= 1'b0;
            r_a0        <= '0;
            r_b0        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_base      <= n_base;
            r_best      <= n_best;
            r_rd_v      <= w_issue;
            r_rd_sweep  <= w_issue && !w_rd_clause;
            r_a0        <= n_a0;
            r_b0        <= n_b0;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_local  <= n_local;
        r_best_o <= n_best_o;
        r_all    <= n_all;
        r_vv     <= n_vv;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.local_score   = r_local;
    assign o_out.best_score    = r_best_o;
    assign o_out.all_satisfied = r_all;
    assign o_out.var_value     = r_vv;
endmodule

// ===== src/m3sat_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module m3sat_ram #(
    parameter int W     = 30,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/m3sat_cell.sv =====
// One variable cell: holds the variable and its flip gain, passes both token lanes on.
`timescale 1ns / 1ps
module m3sat_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  m3sat_pkg::t_var_op i_op,
    input  m3sat_pkg::t_tok_a  i_a,
    input  m3sat_pkg::t_tok_b  i_b,
    output m3sat_pkg::t_tok_a  o_a,
    output m3sat_pkg::t_tok_b  o_b,
    output logic               o_var
);
    import m3sat_pkg::*;

    localparam logic [IDX_W-1:0] ME = IDX_W'(CELL_IDX);

    logic                     r_var;
    logic signed [GAIN_W-1:0] r_gain;
    t_tok_a                   r_a, n_a;
    t_tok_b                   r_b, n_b;
    logic                     w_up, w_dn;

    always_comb begin
        n_a = i_a;
        for (int k = 0; k < NLIT; k++) begin
            if (i_a.lit[k].ok && i_a.lit[k].idx == ME) begin
                n_a.truth[k] = r_var ^ i_a.lit[k].neg;
            end
        end
    end

    // duplicates were removed upstream, so at most one delta hits this cell
    always_comb begin
        w_up = 1'b0;
        w_dn = 1'b0;
        for (int k = 0; k < NLIT; k++) begin
            if (i_b.d[k].idx == ME) begin
                w_up = w_up | i_b.d[k].up;
                w_dn = w_dn | i_b.d[k].dn;
            end
        end
    end

    always_comb begin
        n_b = i_b;
        if (i_b.valid && i_b.sweep && r_gain > i_b.best_gain) begin
            n_b.best_gain = r_gain;
            n_b.best_idx  = ME;
            n_b.found     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_var   <= 1'b0;
            r_gain  <= '0;
            r_a     <= '0;
            r_b     <= '0;
        end else begin
            r_a <= n_a;
            r_b <= n_b;
            if (i_op.wr && i_op.idx == ME) begin
                r_var <= i_op.val;
            end else if (i_op.flip && i_op.idx == ME) begin
                r_var <= ~r_var;
            end
            if (i_b.valid && i_b.sweep) begin
                r_gain <= '0;
            end else if (i_b.valid && w_up) begin
                r_gain <= r_gain + GAIN_W'(1);
            end else if (i_b.valid && w_dn) begin
                r_gain <= r_gain - GAIN_W'(1);
            end
        end
    end

    assign o_a   = r_a;
    assign o_b   = r_b;
    assign o_var = r_var;
endmodule

// ===== src/m3sat_chk.sv =====
// Port-level checker for the hill climber, bound to the top level.
`timescale 1ns / 1ps
module m3sat_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [10:0] i_local_score,
    input logic [10:0] i_best_score,
    input logic        i_var_value
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before transfer");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |-> !(i_out_valid && !i_out_ready))
        else $error("input taken while a result is stalled");

    a_best_covers_local: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_best_score >= i_local_score)
        else $error("best score below local score");

    a_read_only_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_local_score != 11'd0 |-> !i_var_value)
        else $error("variable value on a climb result");
endmodule

bind max_3sat_hill_climb m3sat_chk u_m3sat_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_local_score (o_out.local_score),
    .i_best_score  (o_out.best_score),
    .i_var_value   (o_out.var_value)
);
